// File: rtl/core/spot_pkg.sv
// ----------------------------------------------------------------------------
// spot_pkg: shared types and constants for the script push-op tokenizer
// Word formats, parse phases, byte roles and the parse state record.
// ----------------------------------------------------------------------------
package spot_pkg;

    // Longest script that is parsed; later bytes are flagged as overflow
    localparam int MAX_SCRIPT_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_SCRIPT_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SCRIPT_BYTES);

    // Push opcodes that carry an explicit length field
    localparam logic [7:0] OPC_PUSHDATA1 = 8'h4c;
    localparam logic [7:0] OPC_PUSHDATA2 = 8'h4d;
    localparam logic [7:0] OPC_PUSHDATA4 = 8'h4e;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } spot_phase_t;

    typedef enum logic [1:0] {
        ROLE_OPCODE = 2'd0,
        ROLE_LENGTH = 2'd1,
        ROLE_DATA   = 2'd2
    } spot_role_t;

    // Input word: one script byte
    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } spot_in_t;

    // Result word: description of one script byte
    typedef struct packed {
        logic [7:0]  byte_value;
        spot_role_t  byte_role;
        logic [7:0]  op_code;
        logic [31:0] operand_length;
        logic [15:0] operand_start;
        logic        op_done;
        logic        truncated;
        logic        script_end;
    } spot_out_t;

    // Parse state carried from byte to byte
    typedef struct packed {
        spot_phase_t      phase;
        logic [2:0]       length_bytes_left;
        logic [1:0]       length_shift;
        logic [31:0]      assembled_length;
        logic [31:0]      operand_left;
        logic [7:0]       current_opcode;
        logic [15:0]      operand_offset;
        logic [POS_W-1:0] byte_position;
    } spot_state_t;

    localparam spot_state_t SPOT_STATE_RESET = '{
        phase:             PH_OPCODE,
        length_bytes_left: 3'd0,
        length_shift:      2'd0,
        assembled_length:  32'd0,
        operand_left:      32'd0,
        current_opcode:    8'd0,
        operand_offset:    16'd0,
        byte_position:     '0
    };

endpackage

// File: rtl/core/spot_step.sv
// ----------------------------------------------------------------------------
// spot_step: per-byte parse step
// Combinational update of the parse state and the result word for one byte.
// ----------------------------------------------------------------------------
module spot_step (
    input  spot_pkg::spot_in_t    byte_in,
    input  spot_pkg::spot_state_t state,
    output spot_pkg::spot_state_t state_next,
    output spot_pkg::spot_out_t   result
);

    logic [7:0]                 b;
    logic                       overflow;
    logic [spot_pkg::POS_W-1:0] pos_plus;
    logic [15:0]                start_off;
    logic [2:0]                 len_left_dec;
    logic [31:0]                asm_next;
    logic [31:0]                op_left_dec;
    spot_pkg::spot_state_t      parsed;

    // Shared terms of the step
    assign b            = byte_in.script_byte;
    assign overflow     = (state.byte_position >= spot_pkg::POS_LIMIT);
    assign pos_plus     = state.byte_position + spot_pkg::POS_W'(1);
    assign start_off    = 16'(pos_plus);
    assign len_left_dec = (state.length_bytes_left != 3'd0) ?
                          state.length_bytes_left - 3'd1 : 3'd0;
    assign asm_next     = state.assembled_length |
                          (32'(b) << {state.length_shift, 3'b000});
    assign op_left_dec  = (state.operand_left != 32'd0) ?
                          state.operand_left - 32'd1 : 32'd0;

    // Advance the parse state for this byte
    always_comb
    begin
        parsed = state;
        if (!overflow)
        begin
            case (state.phase)
                spot_pkg::PH_LENGTH:
                begin
                    parsed.assembled_length  = asm_next;
                    parsed.length_shift      = state.length_shift + 2'd1;
                    parsed.length_bytes_left = len_left_dec;
                    if (len_left_dec == 3'd0)
                    begin
                        parsed.operand_offset = start_off;
                        if (asm_next == 32'd0)
                        begin
                            parsed.phase = spot_pkg::PH_OPCODE;
                        end
                        else
                        begin
                            parsed.operand_left = asm_next;
                            parsed.phase        = spot_pkg::PH_DATA;
                        end
                    end
                end
                spot_pkg::PH_DATA:
                begin
                    parsed.operand_left = op_left_dec;
                    if (op_left_dec == 32'd0)
                    begin
                        parsed.phase = spot_pkg::PH_OPCODE;
                    end
                end
                default:
                begin
                    parsed.current_opcode = b;
                    if (b > spot_pkg::OPC_PUSHDATA4)
                    begin
                        parsed.current_opcode = b;
                    end
                    else if (b < spot_pkg::OPC_PUSHDATA1)
                    begin
                        parsed.assembled_length = 32'(b);
                        parsed.operand_offset   = start_off;
                        if (b != 8'd0)
                        begin
                            parsed.operand_left = 32'(b);
                            parsed.phase        = spot_pkg::PH_DATA;
                        end
                    end
                    else
                    begin
                        case (b)
                            spot_pkg::OPC_PUSHDATA1: parsed.length_bytes_left = 3'd1;
                            spot_pkg::OPC_PUSHDATA2: parsed.length_bytes_left = 3'd2;
                            default:                 parsed.length_bytes_left = 3'd4;
                        endcase
                        parsed.length_shift     = 2'd0;
                        parsed.assembled_length = 32'd0;
                        parsed.phase            = spot_pkg::PH_LENGTH;
                    end
                end
            endcase
            parsed.byte_position = pos_plus;
        end
    end

    // Drop back to reset after the last byte of a script
    always_comb
    begin
        state_next = byte_in.last_byte ? spot_pkg::SPOT_STATE_RESET : parsed;
    end

    // Describe the byte
    always_comb
    begin
        result                = '0;
        result.byte_value     = b;
        result.script_end     = byte_in.last_byte;
        result.byte_role      = spot_pkg::ROLE_OPCODE;
        if (overflow)
        begin
            result.op_code   = b;
            result.op_done   = 1'b1;
            result.truncated = 1'b1;
        end
        else
        begin
            case (state.phase)
                spot_pkg::PH_LENGTH:
                begin
                    result.byte_role = spot_pkg::ROLE_LENGTH;
                    result.op_code   = state.current_opcode;
                    if (len_left_dec == 3'd0)
                    begin
                        result.operand_length = asm_next;
                        result.operand_start  = start_off;
                        result.op_done        = (asm_next == 32'd0);
                    end
                end
                spot_pkg::PH_DATA:
                begin
                    result.byte_role      = spot_pkg::ROLE_DATA;
                    result.op_code        = state.current_opcode;
                    result.operand_length = state.assembled_length;
                    result.operand_start  = state.operand_offset;
                    result.op_done        = (op_left_dec == 32'd0);
                end
                default:
                begin
                    result.op_code = b;
                    if (b > spot_pkg::OPC_PUSHDATA4)
                    begin
                        result.op_done = 1'b1;
                    end
                    else if (b < spot_pkg::OPC_PUSHDATA1)
                    begin
                        result.operand_length = 32'(b);
                        result.operand_start  = start_off;
                        result.op_done        = (b == 8'd0);
                    end
                end
            endcase
            // Flag a script that ends inside an operation
            if (byte_in.last_byte && (parsed.phase != spot_pkg::PH_OPCODE))
            begin
                result.op_done   = 1'b1;
                result.truncated = 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/script_push_op_tokenizer.sv
// ----------------------------------------------------------------------------
// script_push_op_tokenizer: script push-op tokenizer
// Splits a streamed script into opcodes, push length bytes and operand bytes.
// ----------------------------------------------------------------------------
//  channel   valid          ready          word
//  input     byte_valid     byte_ready     byte_word   (script byte, last flag)
//  output    result_valid   result_ready   result_word (role, opcode, operand)
//
//  One byte per cycle sustained while result_ready holds; a byte's result
//  word passes two registers: the byte is held in the input register while
//  the parse step runs, and its result is then loaded into the result
//  register. Nothing limits the rate but the handshakes.
//  Reset clears the parse state and both valid flags; no clearing pass.
//  A stalled output holds its word and backs up into the input register.
// ----------------------------------------------------------------------------
module script_push_op_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  spot_pkg::spot_in_t  byte_word,
    output logic                result_valid,
    input  logic                result_ready,
    output spot_pkg::spot_out_t result_word
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    spot_pkg::spot_in_t    s1_word_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    spot_pkg::spot_out_t   out_word_reg;
    spot_pkg::spot_state_t state_reg;
    spot_pkg::spot_state_t state_next;
    spot_pkg::spot_out_t   step_result;
    logic                  out_free;
    logic                  s1_adv;
    logic                  byte_take;

    // Handshake control
    assign out_free   = !out_valid_reg || result_ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign byte_ready = !s1_valid_reg || out_free;
    assign byte_take  = byte_valid && byte_ready;

    assign s1_valid_next  = byte_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !result_ready);

    // Parse step
    spot_step u_step (
        .byte_in    (s1_word_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= spot_pkg::SPOT_STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Capture payload words
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            s1_word_reg <= byte_word;
        end
        if (s1_adv)
        begin
            out_word_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // A truncated operation is always a completed one
    a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_word_reg.truncated || out_word_reg.op_done))
        else $error("truncated without op_done");

    // A last byte returns the parser to the start of a script
    a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_word_reg.last_byte) |=>
        (state_reg.byte_position == '0 && state_reg.phase == spot_pkg::PH_OPCODE))
        else $error("state not reset after last byte");

    // Position counter saturates at the script limit
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_position <= spot_pkg::POS_LIMIT)
        else $error("byte position past limit");

    // Operand phase always has bytes left to take
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == spot_pkg::PH_DATA) |-> (state_reg.operand_left != 32'd0))
        else $error("operand phase with nothing left");

endmodule
